/* sv/bba_pkg.sv */
// Shared constants, codes and types of the bitmap block allocator.
`default_nettype none

package bba_pkg;

    localparam int MAX_BLOCKS   = 32768;
    localparam int WORD_BITS    = 32;
    localparam int BITMAP_DEPTH = MAX_BLOCKS / WORD_BITS;
    localparam int WORD_IDX_W   = $clog2(BITMAP_DEPTH);
    localparam int BIT_IDX_W    = $clog2(WORD_BITS);
    localparam int BLK_W        = WORD_IDX_W + BIT_IDX_W;
    localparam int CNT_W        = 16;
    localparam int FUNC_W       = 2;
    localparam int STATUS_W     = 2;

    localparam int IN_TDATA_W   = 80;
    localparam int OUT_TDATA_W  = 40;

    localparam logic [CNT_W-1:0] TOTAL_RESET = CNT_W'(MAX_BLOCKS);

    typedef enum logic [FUNC_W-1:0] {
        FN_ALLOC     = 2'd0,
        FN_FREE      = 2'd1,
        FN_LOAD      = 2'd2,
        FN_SET_COUNT = 2'd3
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 2'd0,
        ST_NO_SPACE     = 2'd1,
        ST_RANGE        = 2'd2,
        ST_ALREADY_FREE = 2'd3
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_EXEC    = 5'b00010,
        S_SCAN    = 5'b00100,
        S_FREE_RD = 5'b01000,
        S_FINISH  = 5'b10000
    } t_state;

endpackage

`default_nettype wire

/* sv/bitmap_block_allocator_top.sv */
// Top level of the first-fit bitmap block allocator with its bitmap memory.
//
// Channel | Dir | Handshake           | Payload
// --------+-----+---------------------+-------------------------------------------------
// s       | in  | i_s_tvalid/o_s_tready | tuser: func; tdata: block, word index, data, count
// m       | out | o_m_tvalid/i_m_tready | tdata: status, granted_block, free_count
// cfg     | in  | i_cfg_wr_en         | i_cfg_wr_data: block count
//
// A load, a count set or an out-of-range free is done in S_EXEC before S_FINISH;
// any other free first reads its bitmap word in S_FREE_RD, and an allocation reads
// bitmap words one by one in S_SCAN through the single read port of the bitmap
// memory (none when the block count is zero, at most 1024).
// One request is worked on at a time; the next beat is taken once it has finished.
// A finished result waits in the output register while the next request runs.
// Reset is synchronous; the bitmap itself is not cleared and must be loaded first.
`default_nettype none

module bitmap_block_allocator_top (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_wr_en,
    input  wire logic [bba_pkg::CNT_W-1:0]       i_cfg_wr_data,
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    // Fields from bit 0: block_number[14:0], word_index[24:15], word_data[56:25],
    // count_value[72:57], zero fill.
    input  wire logic [bba_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    // Fields from bit 0: func[1:0].
    input  wire logic [bba_pkg::FUNC_W-1:0]      i_s_tuser,
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    // Fields from bit 0: status[1:0], granted_block[16:2], free_count[32:17],
    // zero fill.
    output logic [bba_pkg::OUT_TDATA_W-1:0]      o_m_tdata
);

    localparam int WW = bba_pkg::WORD_BITS;
    localparam int AW = bba_pkg::WORD_IDX_W;
    localparam int BW = bba_pkg::BIT_IDX_W;
    localparam int KW = bba_pkg::BLK_W;
    localparam int CW = bba_pkg::CNT_W;

    logic [WW-1:0] mem [bba_pkg::BITMAP_DEPTH];

    bba_pkg::t_state  r_state, n_state;
    bba_pkg::t_func   r_func;
    logic [KW-1:0]    r_blk;
    logic [AW-1:0]    r_widx;
    logic [WW-1:0]    r_wdata;
    logic [CW-1:0]    r_cval;
    logic [CW-1:0]    r_total;
    logic [CW-1:0]    r_free_cnt, n_free_cnt;
    logic [AW-1:0]    r_scan_idx, n_scan_idx;
    bba_pkg::t_status r_status, n_status;
    logic [KW-1:0]    r_granted, n_granted;
    logic             r_m_valid;
    bba_pkg::t_status r_out_status;
    logic [KW-1:0]    r_out_granted;
    logic [CW-1:0]    r_out_count;
    logic [WW-1:0]    r_rd_data;

    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [WW-1:0]    wr_data;

    logic [CW-1:0]    limit;
    logic [CW-1:0]    limit_m1;
    logic [AW-1:0]    last_word;
    logic [BW-1:0]    last_bit;
    logic [WW-1:0]    beyond_mask;
    logic [WW-1:0]    free_bits;
    logic [WW-1:0]    low_oh;
    logic [BW-1:0]    low_pos;
    logic             out_free;
    logic             s_beat;

    assign s_beat     = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == bba_pkg::S_IDLE);
    assign out_free   = !r_m_valid || i_m_tready;

    assign limit     = (r_total > bba_pkg::TOTAL_RESET) ? bba_pkg::TOTAL_RESET : r_total;
    assign limit_m1  = limit - CW'(1);
    assign last_word = limit_m1[BW +: AW];
    assign last_bit  = limit_m1[BW-1:0];

    always_comb begin
        for (int i = 0; i < WW; i++) begin
            beyond_mask[i] = (r_scan_idx == last_word) && (BW'(i) > last_bit);
        end
        free_bits = ~(r_rd_data | beyond_mask);
        low_oh    = free_bits & (~free_bits + WW'(1));
        low_pos   = '0;
        for (int i = 0; i < WW; i++) begin
            if (low_oh[i]) begin
                low_pos = low_pos | BW'(i);
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        n_free_cnt = r_free_cnt;
        n_scan_idx = r_scan_idx;
        n_status   = r_status;
        n_granted  = r_granted;
        rd_en      = 1'b0;
        rd_addr    = '0;
        wr_en      = 1'b0;
        wr_addr    = r_widx;
        wr_data    = r_wdata;
        unique case (r_state)
            bba_pkg::S_IDLE: begin
                if (s_beat) begin
                    n_state = bba_pkg::S_EXEC;
                end
            end
            bba_pkg::S_EXEC: begin
                n_status  = bba_pkg::ST_OK;
                n_granted = '0;
                n_state   = bba_pkg::S_FINISH;
                unique case (r_func)
                    bba_pkg::FN_ALLOC: begin
                        if (limit == '0) begin
                            n_status = bba_pkg::ST_NO_SPACE;
                        end else begin
                            rd_en      = 1'b1;
                            rd_addr    = '0;
                            n_scan_idx = '0;
                            n_state    = bba_pkg::S_SCAN;
                        end
                    end
                    bba_pkg::FN_FREE: begin
                        if (CW'(r_blk) >= limit) begin
                            n_status = bba_pkg::ST_RANGE;
                        end else begin
                            rd_en   = 1'b1;
                            rd_addr = r_blk[BW +: AW];
                            n_state = bba_pkg::S_FREE_RD;
                        end
                    end
                    bba_pkg::FN_LOAD: begin
                        wr_en = 1'b1;
                    end
                    bba_pkg::FN_SET_COUNT: begin
                        n_free_cnt = r_cval;
                    end
                endcase
            end
            bba_pkg::S_SCAN: begin
                if (free_bits != '0) begin
                    wr_en     = 1'b1;
                    wr_addr   = r_scan_idx;
                    wr_data   = r_rd_data | low_oh;
                    n_granted = {r_scan_idx, low_pos};
                    if (r_free_cnt != '0) begin
                        n_free_cnt = r_free_cnt - CW'(1);
                    end
                    n_state = bba_pkg::S_FINISH;
                end else if (r_scan_idx == last_word) begin
                    n_status = bba_pkg::ST_NO_SPACE;
                    n_state  = bba_pkg::S_FINISH;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = r_scan_idx + AW'(1);
                    n_scan_idx = r_scan_idx + AW'(1);
                end
            end
            bba_pkg::S_FREE_RD: begin
                if (!r_rd_data[r_blk[BW-1:0]]) begin
                    n_status = bba_pkg::ST_ALREADY_FREE;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = r_blk[BW +: AW];
                    wr_data = r_rd_data & ~(WW'(1) << r_blk[BW-1:0]);
                    if (r_free_cnt != {CW{1'b1}}) begin
                        n_free_cnt = r_free_cnt + CW'(1);
                    end
                end
                n_state = bba_pkg::S_FINISH;
            end
            bba_pkg::S_FINISH: begin
                if (out_free) begin
                    n_state = bba_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bba_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= bba_pkg::S_IDLE;
            r_total    <= bba_pkg::TOTAL_RESET;
            r_free_cnt <= '0;
            r_m_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_free_cnt <= n_free_cnt;
            if (i_cfg_wr_en) begin
                r_total <= i_cfg_wr_data;
            end
            if (r_state == bba_pkg::S_FINISH && out_free) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_beat) begin
            r_func  <= bba_pkg::t_func'(i_s_tuser);
            r_blk   <= i_s_tdata[KW-1:0];
            r_widx  <= i_s_tdata[KW +: AW];
            r_wdata <= i_s_tdata[KW+AW +: WW];
            r_cval  <= i_s_tdata[KW+AW+WW +: CW];
        end
        r_scan_idx <= n_scan_idx;
        r_status   <= n_status;
        r_granted  <= n_granted;
        if (r_state == bba_pkg::S_FINISH && out_free) begin
            r_out_status  <= r_status;
            r_out_granted <= r_granted;
            r_out_count   <= r_free_cnt;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {(bba_pkg::OUT_TDATA_W - bba_pkg::STATUS_W - KW - CW)'(0),
                         r_out_count, r_out_granted, r_out_status};

endmodule

`default_nettype wire

/* sv/bba_checker.sv */
// Port-level checker of the bitmap block allocator and its bind to the top level.
`default_nettype none

module bba_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_s_tvalid,
    input wire logic                            o_s_tready,
    input wire logic                            o_m_tvalid,
    input wire logic                            i_m_tready,
    input wire logic [bba_pkg::OUT_TDATA_W-1:0] o_m_tdata
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output beat valid right after reset");

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled output beat changed");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input taken while a request is in progress");

    a_grant_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[1:0] != bba_pkg::ST_OK) |-> o_m_tdata[16:2] == '0)
        else $error("nonzero block number with a failing status");

    a_fill_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[bba_pkg::OUT_TDATA_W-1:33] == '0)
        else $error("fill bits of output beat not zero");

endmodule

bind bitmap_block_allocator_top bba_checker u_bba_checker (.*);

`default_nettype wire
